// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also active during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/isort_pkg.sv
package isort_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int VAL_W     = 32;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } isort_state_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                    insert;
    logic                    shift;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

  // chain status seen by the controller
  typedef struct packed {
    logic full;
    logic head_occ;
    logic tail;
  } chain_status_t;

endpackage

// File: rtl/core/isort_cell.sv
module isort_cell
  import isort_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cell_cmd_t               cmd,
  input  logic                    prev_gt,
  input  logic                    prev_occ,
  input  logic signed [VAL_W-1:0] prev_val,
  input  logic                    next_occ,
  input  logic signed [VAL_W-1:0] next_val,
  output logic                    gt,
  output logic                    occ,
  output logic signed [VAL_W-1:0] val
);

  logic                    occ_r, occ_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;

  assign gt  = occ_r && (val_r > cmd.value);
  assign occ = occ_r;
  assign val = val_r;

  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    if (cmd.shift) begin
      occ_nxt = next_occ;
      val_nxt = next_val;
    end else if (cmd.insert) begin
      if (!occ_r || gt) begin
        if (prev_gt) begin
          occ_nxt = 1'b1;
          val_nxt = prev_val;
        end else if (prev_occ) begin
          occ_nxt = 1'b1;
          val_nxt = cmd.value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: rtl/core/isort_ctrl.sv
module isort_ctrl
  import isort_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic                    in_tlast,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_tready,
  input  chain_status_t           status,
  output logic                    in_tready,
  output logic                    out_tvalid,
  output logic                    overflow,
  output cell_cmd_t               cmd
);

  isort_state_t state_r, state_nxt;
  logic         dropped_r, dropped_nxt;
  logic         in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_acc && in_tlast) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_acc && status.tail) state_nxt = ST_FILL;
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    dropped_nxt = dropped_r;
    unique case (state_r)
      ST_FILL: begin
        in_tready = 1'b1;
        if (in_tvalid && status.full) dropped_nxt = 1'b1;
      end
      ST_DRAIN: begin
        out_tvalid = status.head_occ;
        if (out_tready && status.head_occ && status.tail) dropped_nxt = 1'b0;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
    cmd.insert = in_acc && !status.full;
    cmd.shift  = out_acc;
    cmd.value  = in_value;
  end

  assign overflow = dropped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_FILL;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

endmodule

// File: rtl/core/insertion_sorter.sv
// channel | dir | tdata            | tlast    | tuser
// in_     | in  | value [31:0]     | last     | -
// out_    | out | value_res [31:0] | last_res | overflow
//
// while filling, one request per cycle: the value is compared against every
// cell at once and the row shifts up in that same cycle
// a closing request is followed by one result per cycle for each stored value,
// drained through the lowest cell and stalled by out_tready; no request is
// taken during the drain
// synchronous active-low reset empties the row and clears the overflow flag
module insertion_sorter
  import isort_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value_res
  output logic        out_tlast,
  output logic        out_tuser   // overflow
);

  cell_cmd_t               cmd;
  chain_status_t           status;
  logic                    cell_gt  [MAX_ITEMS];
  logic                    cell_occ [MAX_ITEMS];
  logic signed [VAL_W-1:0] cell_val [MAX_ITEMS];
  logic                    in_acc, out_acc;

  isort_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_value   ($signed(in_tdata)),
    .out_tready (out_tready),
    .status     (status),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .overflow   (out_tuser),
    .cmd        (cmd)
  );

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                    p_gt, p_occ, n_occ;
    logic signed [VAL_W-1:0] p_val, n_val;

    if (i == 0) begin : g_head
      assign p_gt  = 1'b0;
      assign p_occ = 1'b1;
      assign p_val = '0;
    end else begin : g_body
      assign p_gt  = cell_gt[i-1];
      assign p_occ = cell_occ[i-1];
      assign p_val = cell_val[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign n_occ = 1'b0;
      assign n_val = '0;
    end else begin : g_mid
      assign n_occ = cell_occ[i+1];
      assign n_val = cell_val[i+1];
    end

    isort_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .prev_gt  (p_gt),
      .prev_occ (p_occ),
      .prev_val (p_val),
      .next_occ (n_occ),
      .next_val (n_val),
      .gt       (cell_gt[i]),
      .occ      (cell_occ[i]),
      .val      (cell_val[i])
    );
  end

  assign status.full     = cell_occ[MAX_ITEMS-1];
  assign status.head_occ = cell_occ[0];
  assign status.tail     = !cell_occ[1];

  assign out_tdata = cell_val[0];
  assign out_tlast = status.tail;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

`include "assert_macros.svh"

  `ASSERT_CLK(a_no_overlap, !(in_tready && out_tvalid), "input taken during drain")
  `ASSERT_CLK(a_close_drains, (in_acc && in_tlast) |=> out_tvalid, "closed set did not drain")
  `ASSERT_CLK(a_drain_cont, (out_acc && !out_tlast) |=> out_tvalid, "drain stopped early")
  `ASSERT_CLK(a_tail_frees, (out_acc && out_tlast) |=> (in_tready && !cell_occ[0]), "row not empty")

endmodule
